/* rtl/gpu_ownership_table_defines.svh */
// Assertion macros for the GPU ownership table.
// Taken in by the top level; depends on a clock named clk and a reset named rst.
`ifndef GPU_OWNERSHIP_TABLE_DEFINES_SVH
`define GPU_OWNERSHIP_TABLE_DEFINES_SVH

// Property checked on every rising edge outside reset.
`define GPOT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define GPOT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gpot_pkg.sv */
// Shared types and codes for the GPU ownership table.
// No dependencies.
package gpot_pkg;

  localparam int MAX_GPUS_DEF = 8192;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;
  localparam logic [1:0] OP_HEALTH  = 2'd3;

  // Status codes of a result item.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_PENDING  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_REJECTED = 3'd4;

  // One slot as held in the slot memory.
  typedef struct packed {
    logic [15:0] gpu_id;
    logic [11:0] rack;
    logic [15:0] nic;
    logic        healthy;
    logic        owned;
    logic [31:0] owner_job;
    logic        pending;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

endpackage

/* rtl/gpot_if.sv */
// Valid/ready channel interfaces for the GPU ownership table.
// Request and response payloads; no package dependency.
interface gpot_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] gpu_id;
  logic [11:0] rack_id;
  logic [15:0] nic_id;
  logic [31:0] job_id;
  logic        health_flag;
  logic        last_worker;
  modport source (output valid, op, gpu_id, rack_id, nic_id, job_id, health_flag,
                  last_worker, input ready);
  modport sink (input valid, op, gpu_id, rack_id, nic_id, job_id, health_flag,
                last_worker, output ready);
endinterface

interface gpot_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        owner_valid;
  logic [31:0] owner_job;
  modport source (output valid, status, owner_valid, owner_job, input ready);
  modport sink (input valid, status, owner_valid, owner_job, output ready);
endinterface

/* rtl/gpu_ownership_table.sv */
// Channels:
//   name  dir   handshake    payload
//   req   in    valid/ready  op, gpu_id, rack_id, nic_id, job_id, health_flag, last_worker
//   rsp   out   valid/ready  status, owner_valid, owner_job
// An item that sweeps the table reads every slot below slot_count, one slot memory read a
// cycle; the final worker of an allocation sweeps twice (lookup, then commit). A load with
// no open run skips the sweep. Reset is synchronous and clears control state only; the
// slot memory needs no clearing pass, as only slots below slot_count are read. A stalled
// result holds in the output register while the next item is taken.
// Top level of the GPU ownership table; depends on gpot_pkg, gpot_if, gpot_ram and the
// assertion macro header.
`include "gpu_ownership_table_defines.svh"

module gpu_ownership_table #(
  parameter int MAX_GPUS = gpot_pkg::MAX_GPUS_DEF
) (
  input logic      clk,
  input logic      rst,
  gpot_req_if.sink   req,
  gpot_rsp_if.source rsp
);

  localparam int AW = (MAX_GPUS > 1) ? $clog2(MAX_GPUS) : 1;
  localparam int CW = $clog2(MAX_GPUS + 1);
  localparam int LW = $clog2(MAX_GPUS + 2);

  // Sequencer states.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_FIN   = 2'd2;

  // Sweep kinds.
  localparam logic [2:0] M_CLEAR   = 3'd0;
  localparam logic [2:0] M_ALLOC   = 3'd1;
  localparam logic [2:0] M_COMMIT  = 3'd2;
  localparam logic [2:0] M_RELEASE = 3'd3;
  localparam logic [2:0] M_HEALTH  = 3'd4;

  logic [1:0]    state;
  logic [2:0]    mode;
  logic [CW-1:0] slot_count;
  logic [CW-1:0] rd_idx;
  logic          rd_vld;
  logic [AW-1:0] rd_addr_q;
  logic          found;
  logic          hit_owned;
  logic [31:0]   hit_job;
  logic          own_chk;
  logic          run_open;
  logic [31:0]   run_job;
  logic          run_failed;
  logic [LW-1:0] run_length;

  // Latched item.
  logic [1:0]  op;
  logic [15:0] gpu_id;
  logic [11:0] rack_id;
  logic [15:0] nic_id;
  logic [31:0] job_id;
  logic        health_flag;
  logic        last_worker;

  logic              we;
  logic [AW-1:0]     waddr;
  gpot_pkg::slot_t   wslot;
  gpot_pkg::slot_t   rslot;
  gpot_pkg::slot_t   mslot;
  logic [AW-1:0]     raddr;
  logic [gpot_pkg::SLOT_W-1:0] rdata;

  logic          accept;
  logic          emit;
  logic          sweep_done;
  logic          hit;
  logic          alloc_bad;
  logic          own_hit;
  logic [LW-1:0] len_base;
  logic [LW-1:0] len_next;
  logic [2:0]    status_next;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign emit = (state == S_FIN) && (!rsp.valid || rsp.ready);
  assign sweep_done = (state == S_SWEEP) && !rd_vld && (rd_idx == slot_count);
  assign raddr = rd_idx[AW-1:0];
  assign rslot = gpot_pkg::slot_t'(rdata);

  gpot_ram #(.WIDTH(gpot_pkg::SLOT_W), .DEPTH(MAX_GPUS)) u_slots (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wslot),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Run length for the incoming worker item, saturating one past the table size.
  always_comb begin
    len_base = run_open ? run_length : '0;
    len_next = (len_base <= LW'(MAX_GPUS)) ? len_base + LW'(1) : len_base;
  end

  // Modify the slot read back during a sweep.
  always_comb begin
    mslot     = rslot;
    hit       = !found && (rslot.gpu_id == gpu_id);
    alloc_bad = !rslot.healthy || rslot.owned || rslot.pending;
    own_hit   = own_chk && rslot.owned && (rslot.owner_job == run_job);
    unique case (mode)
      M_ALLOC: begin
        if (hit && !alloc_bad) begin
          mslot.pending = 1'b1;
        end
      end
      M_COMMIT: begin
        if (rslot.pending && !run_failed) begin
          mslot.owned     = 1'b1;
          mslot.owner_job = run_job;
        end
        mslot.pending = 1'b0;
      end
      M_RELEASE: begin
        if (rslot.owned && (rslot.owner_job == job_id)) begin
          mslot.owned     = 1'b0;
          mslot.owner_job = '0;
        end
        mslot.pending = 1'b0;
      end
      M_HEALTH: begin
        if (hit) begin
          mslot.healthy = health_flag;
        end
        mslot.pending = 1'b0;
      end
      default: begin
        mslot.pending = 1'b0;
      end
    endcase
  end

  // Write port: sweep write-back, or the new slot of a load.
  always_comb begin
    we    = 1'b0;
    waddr = rd_addr_q;
    wslot = mslot;
    if (state == S_SWEEP && rd_vld) begin
      we = 1'b1;
    end else if (emit && op == gpot_pkg::OP_LOAD && slot_count < CW'(MAX_GPUS)) begin
      we    = 1'b1;
      waddr = slot_count[AW-1:0];
      wslot = '{gpu_id: gpu_id, rack: rack_id, nic: nic_id, healthy: 1'b1,
                owned: 1'b0, owner_job: '0, pending: 1'b0};
    end
  end

  // Result status of the item being finished.
  always_comb begin
    status_next = gpot_pkg::ST_OK;
    unique case (op)
      gpot_pkg::OP_LOAD: begin
        if (slot_count >= CW'(MAX_GPUS)) begin
          status_next = gpot_pkg::ST_FULL;
        end
      end
      gpot_pkg::OP_ALLOC: begin
        if (!last_worker) begin
          status_next = gpot_pkg::ST_PENDING;
        end else if (run_failed) begin
          status_next = gpot_pkg::ST_REJECTED;
        end
      end
      gpot_pkg::OP_RELEASE: begin
        status_next = gpot_pkg::ST_OK;
      end
      default: begin
        if (!found) begin
          status_next = gpot_pkg::ST_UNKNOWN;
        end
      end
    endcase
  end

  // Item payload latch.
  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= req.op;
      gpu_id      <= req.gpu_id;
      rack_id     <= req.rack_id;
      nic_id      <= req.nic_id;
      job_id      <= req.job_id;
      health_flag <= req.health_flag;
      last_worker <= req.last_worker;
    end
  end

  // Sequencer, sweep pipeline and run state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= M_CLEAR;
      slot_count <= '0;
      rd_idx     <= '0;
      rd_vld     <= 1'b0;
      rd_addr_q  <= '0;
      found      <= 1'b0;
      hit_owned  <= 1'b0;
      hit_job    <= '0;
      own_chk    <= 1'b0;
      run_open   <= 1'b0;
      run_job    <= '0;
      run_failed <= 1'b0;
      run_length <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && !emit) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_idx <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            state  <= S_SWEEP;
            if (req.op == gpot_pkg::OP_ALLOC) begin
              mode       <= M_ALLOC;
              own_chk    <= !run_open;
              run_open   <= 1'b1;
              run_length <= len_next;
              if (!run_open) begin
                run_job    <= req.job_id;
                run_failed <= (len_next > LW'(slot_count));
              end else if (len_next > LW'(slot_count)) begin
                run_failed <= 1'b1;
              end
            end else begin
              run_open   <= 1'b0;
              run_failed <= 1'b0;
              run_length <= '0;
              own_chk    <= 1'b0;
              if (req.op == gpot_pkg::OP_LOAD) begin
                mode <= M_CLEAR;
                if (!run_open) begin
                  state <= S_FIN;
                end
              end else if (req.op == gpot_pkg::OP_RELEASE) begin
                mode <= M_RELEASE;
              end else begin
                mode <= M_HEALTH;
              end
            end
          end
        end
        S_SWEEP: begin
          // Issue the next read; its data is processed in the following cycle.
          if (rd_idx < slot_count) begin
            rd_vld    <= 1'b1;
            rd_addr_q <= rd_idx[AW-1:0];
            rd_idx    <= rd_idx + CW'(1);
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (hit) begin
              found     <= 1'b1;
              hit_owned <= rslot.owned;
              hit_job   <= rslot.owner_job;
            end
            if (mode == M_ALLOC && ((hit && alloc_bad) || own_hit)) begin
              run_failed <= 1'b1;
            end
          end
          if (sweep_done) begin
            if (mode == M_ALLOC) begin
              if (!found) begin
                run_failed <= 1'b1;
              end
              if (last_worker) begin
                mode   <= M_COMMIT;
                rd_idx <= '0;
              end else begin
                state <= S_FIN;
              end
            end else begin
              state <= S_FIN;
            end
          end
        end
        default: begin
          if (emit) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= status_next;
            rsp.owner_valid <= (op == gpot_pkg::OP_HEALTH) && found && hit_owned;
            rsp.owner_job   <= ((op == gpot_pkg::OP_HEALTH) && found && hit_owned) ?
                               hit_job : '0;
            if (op == gpot_pkg::OP_LOAD && slot_count < CW'(MAX_GPUS)) begin
              slot_count <= slot_count + CW'(1);
            end
            if (op == gpot_pkg::OP_ALLOC && last_worker) begin
              run_open   <= 1'b0;
              run_failed <= 1'b0;
              run_length <= '0;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // The slot count never passes the table size and only grows one slot at a time.
  `GPOT_ASSERT(a_count_range, slot_count <= CW'(MAX_GPUS), "slot count beyond table size")
  `GPOT_ASSERT(a_count_step, !$stable(slot_count) |-> slot_count == $past(slot_count) + CW'(1), "slot count jumped")
  // The sweep never reads past the loaded slots.
  `GPOT_ASSERT(a_sweep_bound, rd_idx <= slot_count, "sweep index beyond loaded slots")
  // An open run always has a non-zero length.
  `GPOT_ASSERT(a_run_len, run_open |-> run_length != '0, "open run without workers")

endmodule

/* rtl/gpot_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gpot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read first (a read of the address being written returns the old data); read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
